// ===== rtl/sgm_path_cost_aggregator_core_assert.svh =====
// Assertion macros for the path cost aggregator RTL.
// Uses the clk_i and rst_ni names of the including module; no other dependencies.
`ifndef SGM_PATH_COST_AGGREGATOR_CORE_ASSERT_SVH
`define SGM_PATH_COST_AGGREGATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define SGM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Check that a condition never holds at a rising clock edge
`define SGM_ASSERT_NEVER(label, cond, msg) \
  `SGM_ASSERT(label, !(cond), msg)
`else
`define SGM_ASSERT(label, prop, msg)
`define SGM_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== rtl/sgm_pkg.sv =====
// Shared types, constants and helper functions for the path cost aggregator.
// No dependencies; used by every module in rtl/.
package sgm_pkg;

  // Default sizing
  localparam int NUM_DISP_DEF    = 64;
  localparam int CENSUS_BITS_DEF = 64;

  // Fixed field widths
  localparam int CENSUS_W   = 64;
  localparam int COLUMN_W   = 12;
  localparam int COST_W     = 8;
  localparam int MATCH_W    = 7;
  localparam int DISP_OUT_W = 6;

  // Cost constants
  localparam logic [COST_W-1:0]  COST_MAX = 8'hFF;
  localparam logic [MATCH_W-1:0] OOR_COST = 7'd64;

  // Configuration register reset values
  localparam logic [COST_W-1:0] SMALL_PENALTY_RST = 8'd10;
  localparam logic [COST_W-1:0] LARGE_PENALTY_RST = 8'd120;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_SMALL_PENALTY = 1'b0;
  localparam logic REG_LARGE_PENALTY = 1'b1;

  // Input request: one disparity of one pixel
  typedef struct packed {
    logic [CENSUS_W-1:0] census_left;
    logic [CENSUS_W-1:0] census_right;
    logic [COLUMN_W-1:0] column;
    logic                line_start;
  } in_req_t;

  // Output request: one aggregated cost
  typedef struct packed {
    logic [COST_W-1:0]     path_cost;
    logic [DISP_OUT_W-1:0] disparity;
    logic                  pixel_done;
  } out_req_t;

  // Penalty registers
  typedef struct packed {
    logic [COST_W-1:0] small_penalty;
    logic [COST_W-1:0] large_penalty;
  } cfg_t;

  // Previous-pixel costs around the current disparity
  typedef struct packed {
    logic [COST_W-1:0] lo;
    logic [COST_W-1:0] mid;
    logic [COST_W-1:0] hi;
  } taps_t;

  // Add two costs, clip at COST_MAX
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  // Subtract the previous minimum, floor at zero
  function automatic logic [COST_W-1:0] less_min(input logic [COST_W-1:0] v,
                                                 input logic [COST_W-1:0] m);
    return (v > m) ? (v - m) : '0;
  endfunction

  // Smaller of two costs
  function automatic logic [COST_W-1:0] min2(input logic [COST_W-1:0] a,
                                             input logic [COST_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

endpackage

// ===== rtl/sgm_cfg_regs.sv =====
// APB register file holding the two smoothness penalties.
// Depends on sgm_pkg for the register map, reset values and cfg_t.
module sgm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sgm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sgm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sgm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output sgm_pkg::cfg_t                    cfg_o
);

  logic [sgm_pkg::COST_W-1:0] small_q, small_d;
  logic [sgm_pkg::COST_W-1:0] large_q, large_d;
  logic                       wr_en;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Decode the write
  always_comb begin
    small_d = small_q;
    large_d = large_q;
    if (wr_en) begin
      case (reg_sel)
        sgm_pkg::REG_SMALL_PENALTY: small_d = pwdata[sgm_pkg::COST_W-1:0];
        sgm_pkg::REG_LARGE_PENALTY: large_d = pwdata[sgm_pkg::COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_q <= sgm_pkg::SMALL_PENALTY_RST;
      large_q <= sgm_pkg::LARGE_PENALTY_RST;
    end else begin
      small_q <= small_d;
      large_q <= large_d;
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      sgm_pkg::REG_SMALL_PENALTY: prdata = sgm_pkg::APB_DATA_W'(small_q);
      sgm_pkg::REG_LARGE_PENALTY: prdata = sgm_pkg::APB_DATA_W'(large_q);
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o.small_penalty = small_q;
  assign cfg_o.large_penalty = large_q;

endmodule

// ===== rtl/sgm_match_cost.sv =====
// Census matching cost: Hamming distance, or a fixed cost left of the image edge.
// Depends on sgm_pkg for field widths and the out-of-range cost.
module sgm_match_cost #(
  parameter int CENSUS_BITS = sgm_pkg::CENSUS_BITS_DEF,
  parameter int DISP_W      = 6
) (
  input  logic [sgm_pkg::CENSUS_W-1:0] census_left_i,
  input  logic [sgm_pkg::CENSUS_W-1:0] census_right_i,
  input  logic [sgm_pkg::COLUMN_W-1:0] column_i,
  input  logic [DISP_W-1:0]            disp_i,
  output logic [sgm_pkg::MATCH_W-1:0]  match_o
);

  localparam logic [sgm_pkg::CENSUS_W-1:0] CENSUS_MASK =
    (CENSUS_BITS >= sgm_pkg::CENSUS_W) ? {sgm_pkg::CENSUS_W{1'b1}} :
    ((sgm_pkg::CENSUS_W'(1) << CENSUS_BITS) - sgm_pkg::CENSUS_W'(1));

  logic [sgm_pkg::CENSUS_W-1:0] diff;
  logic [sgm_pkg::MATCH_W-1:0]  hamming;
  logic                         out_of_range;

  // Count differing census bits within the used width
  assign diff         = (census_left_i ^ census_right_i) & CENSUS_MASK;
  assign hamming      = sgm_pkg::MATCH_W'($countones(diff));
  assign out_of_range = column_i < sgm_pkg::COLUMN_W'(disp_i);
  assign match_o      = out_of_range ? sgm_pkg::OOR_COST : hamming;

endmodule

// ===== rtl/sgm_prev_line.sv =====
// Shift line holding the last NUM_DISP+1 aggregated costs; fixed taps give the
// previous pixel's costs at d-1, d and d+1. Depends on sgm_pkg for taps_t.
module sgm_prev_line #(
  parameter int NUM_DISP = sgm_pkg::NUM_DISP_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [sgm_pkg::COST_W-1:0] cost_i,
  input  logic                       last_i,
  output sgm_pkg::taps_t             taps_o
);

  logic [sgm_pkg::COST_W-1:0] line_q [NUM_DISP+1];
  logic                       filled_q;

  // Advance the line by one cost per accepted request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      line_q[0] <= cost_i;
      for (int k = 1; k <= NUM_DISP; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  // Mark the line usable once a full pixel vector has gone in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
    end else if (push_i && last_i) begin
      filled_q <= 1'b1;
    end
  end

  // Before the first full pixel the previous vector reads as all maximum
  assign taps_o.lo  = filled_q ? line_q[NUM_DISP]   : sgm_pkg::COST_MAX;
  assign taps_o.mid = filled_q ? line_q[NUM_DISP-1] : sgm_pkg::COST_MAX;
  assign taps_o.hi  = filled_q ? line_q[NUM_DISP-2] : sgm_pkg::COST_MAX;

endmodule

// ===== rtl/sgm_path_step.sv =====
// One aggregation step: match cost plus the cheapest transition from the
// previous pixel. Depends on sgm_pkg for types and saturating helpers.
module sgm_path_step #(
  parameter int NUM_DISP = sgm_pkg::NUM_DISP_DEF,
  parameter int DISP_W   = 6
) (
  input  logic [sgm_pkg::MATCH_W-1:0] match_i,
  input  logic                        line_start_i,
  input  logic [DISP_W-1:0]           disp_i,
  input  sgm_pkg::taps_t              taps_i,
  input  logic [sgm_pkg::COST_W-1:0]  prev_min_i,
  input  sgm_pkg::cfg_t               cfg_i,
  output logic [sgm_pkg::COST_W-1:0]  cost_o
);

  localparam logic [DISP_W-1:0] LAST_DISP = DISP_W'(NUM_DISP - 1);

  logic [sgm_pkg::COST_W-1:0] same_t;
  logic [sgm_pkg::COST_W-1:0] lo_t;
  logic [sgm_pkg::COST_W-1:0] hi_t;
  logic [sgm_pkg::COST_W-1:0] best;
  logic [sgm_pkg::COST_W-1:0] match_w;

  // Transition terms; a missing neighbor costs the maximum
  assign same_t = sgm_pkg::less_min(taps_i.mid, prev_min_i);
  assign lo_t   = (disp_i == '0) ? sgm_pkg::COST_MAX :
                  sgm_pkg::sat_add(sgm_pkg::less_min(taps_i.lo, prev_min_i),
                                   cfg_i.small_penalty);
  assign hi_t   = (disp_i == LAST_DISP) ? sgm_pkg::COST_MAX :
                  sgm_pkg::sat_add(sgm_pkg::less_min(taps_i.hi, prev_min_i),
                                   cfg_i.small_penalty);

  // Pick the cheapest of the four
  assign best = sgm_pkg::min2(sgm_pkg::min2(same_t, lo_t),
                              sgm_pkg::min2(hi_t, cfg_i.large_penalty));

  assign match_w = sgm_pkg::COST_W'(match_i);

  // At line start only the raw match cost counts
  assign cost_o = line_start_i ? match_w : sgm_pkg::sat_add(match_w, best);

endmodule

// ===== rtl/sgm_path_cost_aggregator_core.sv =====
// Top level of the path cost aggregator: input register, aggregation step,
// output register. Depends on sgm_pkg and all sgm_* modules.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------
//   in      | sink      | in_valid_i / in_stall_o   | in_req_i  (in_req_t)
//   out     | source    | out_valid_o / out_stall_i | out_req_o (out_req_t)
//   cfg     | sink      | APB psel/penable/pready   | pwdata, prdata
//
// One request per cycle sustained while out is not stalled; out_valid_o rises
// when the input register moves its request on into the output register.
// Reset clears control state and sets the penalties to their defaults; no
// clearing pass is needed, the previous cost vector reads as maximum until the
// first pixel is complete. A stall on out holds the output register; once the
// input register is full it holds that too and raises in_stall_o.
module sgm_path_cost_aggregator_core #(
  parameter int NUM_DISP    = sgm_pkg::NUM_DISP_DEF,
  parameter int CENSUS_BITS = sgm_pkg::CENSUS_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sgm_pkg::in_req_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sgm_pkg::out_req_t              out_req_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sgm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sgm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sgm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int                DISP_W    = $clog2(NUM_DISP);
  localparam logic [DISP_W-1:0] LAST_DISP = DISP_W'(NUM_DISP - 1);
  localparam logic [sgm_pkg::DISP_OUT_W-1:0] LAST_OUT =
    sgm_pkg::DISP_OUT_W'(NUM_DISP - 1);

  sgm_pkg::cfg_t              cfg;
  sgm_pkg::taps_t             taps;
  sgm_pkg::in_req_t           a_req_q;
  sgm_pkg::out_req_t          out_req_q, out_req_d;
  logic                       a_valid_q, a_valid_d;
  logic                       out_valid_q, out_valid_d;
  logic [DISP_W-1:0]          disp_q, disp_d;
  logic [sgm_pkg::COST_W-1:0] rmin_q, rmin_d;
  logic [sgm_pkg::COST_W-1:0] pmin_q, pmin_d;
  logic [sgm_pkg::MATCH_W-1:0] match;
  logic [sgm_pkg::COST_W-1:0] cost;
  logic [sgm_pkg::COST_W-1:0] rmin_new;
  logic                       out_ready;
  logic                       in_acc;
  logic                       a_adv;
  logic                       last;

  sgm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the input register moves on whenever the output side frees up
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = a_valid_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign a_adv      = a_valid_q && out_ready;
  assign last       = disp_q == LAST_DISP;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_req_q <= in_req_i;
    end
  end

  sgm_match_cost #(
    .CENSUS_BITS (CENSUS_BITS),
    .DISP_W      (DISP_W)
  ) u_match (
    .census_left_i  (a_req_q.census_left),
    .census_right_i (a_req_q.census_right),
    .column_i       (a_req_q.column),
    .disp_i         (disp_q),
    .match_o        (match)
  );

  sgm_prev_line #(
    .NUM_DISP (NUM_DISP)
  ) u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (a_adv),
    .cost_i (cost),
    .last_i (last),
    .taps_o (taps)
  );

  sgm_path_step #(
    .NUM_DISP (NUM_DISP),
    .DISP_W   (DISP_W)
  ) u_step (
    .match_i      (match),
    .line_start_i (a_req_q.line_start),
    .disp_i       (disp_q),
    .taps_i       (taps),
    .prev_min_i   (pmin_q),
    .cfg_i        (cfg),
    .cost_o       (cost)
  );

  assign rmin_new = sgm_pkg::min2(rmin_q, cost);

  // Next state: counter, minima, valid flags, result
  always_comb begin
    a_valid_d   = a_valid_q;
    out_valid_d = out_valid_q;
    disp_d      = disp_q;
    rmin_d      = rmin_q;
    pmin_d      = pmin_q;
    out_req_d   = out_req_q;
    if (out_ready) begin
      out_valid_d = a_valid_q;
    end
    if (in_acc) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
    if (a_adv) begin
      out_req_d.path_cost  = cost;
      out_req_d.disparity  = sgm_pkg::DISP_OUT_W'(disp_q);
      out_req_d.pixel_done = last;
      if (last) begin
        disp_d = '0;
        rmin_d = sgm_pkg::COST_MAX;
        pmin_d = rmin_new;
      end else begin
        disp_d = disp_q + DISP_W'(1);
        rmin_d = rmin_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      disp_q      <= '0;
      rmin_q      <= sgm_pkg::COST_MAX;
      pmin_q      <= '0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      disp_q      <= disp_d;
      rmin_q      <= rmin_d;
      pmin_q      <= pmin_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    out_req_q <= out_req_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  `include "sgm_path_cost_aggregator_core_assert.svh"

  `SGM_ASSERT_NEVER(a_disp_range, disp_q > LAST_DISP, "disparity counter out of range")
  `SGM_ASSERT(a_done_last,
    out_valid_q && out_req_q.pixel_done |-> out_req_q.disparity == LAST_OUT,
    "pixel_done off the last disparity")
  `SGM_ASSERT(a_wrap,
    a_adv && last |=> disp_q == '0 && rmin_q == sgm_pkg::COST_MAX,
    "counter or minimum not restarted at pixel end")
  `SGM_ASSERT(a_result_loaded, a_adv |=> out_valid_q,
    "advanced request lost before the output register")
  `SGM_ASSERT(a_min_bound,
    out_valid_q && !$past(out_valid_q) |->
      rmin_q <= out_req_q.path_cost || out_req_q.pixel_done,
    "running minimum above a fresh result")

endmodule
